// ===== rtl/crc8fr_pkg.sv =====
// Package for the CRC-8 framed packet receiver.
// Holds frame marker bytes, the CRC polynomial, the length limit default and the CRC step.
// No dependencies.
`default_nettype none

package crc8fr_pkg;

  localparam logic [7:0] HDR0        = 8'h55;
  localparam logic [7:0] HDR1        = 8'hAA;
  localparam logic [7:0] CRC_POLY    = 8'h8C;
  localparam int         MAX_PAYLOAD = 12;
  localparam int         SLOT_N      = 5;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  localparam logic [7:0] HDR_CRC = crc8_byte(crc8_byte(8'h00, HDR0), HDR1);

endpackage

`default_nettype wire

// ===== rtl/crc8_framed_packet_receiver.sv =====
// Receiver for framed byte packets: 0x55 0xAA header, length, payload, CRC-8 check, trailer.
// Emits two signed speeds and a flag per good frame. Depends on crc8fr_pkg.
// The result is registered: res_valid rises in the cycle after the second trailer byte is accepted.
// Throughput: one byte beat per cycle unless stalled; the per-byte CRC step is one unrolled stage.
// Input stalls only while a result is held and the next byte would complete another frame.
// Reset: synchronous, active high; hunting for the header, CRC and counters zero,
// stored frame bytes zero, no result held.
`default_nettype none

module crc8_framed_packet_receiver #(
  parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rx_valid,
  output      logic               rx_stall,
  input  wire logic [7:0]         rx_byte,
  output      logic               res_valid,
  input  wire logic               res_stall,
  output      logic signed [15:0] left_speed,
  output      logic signed [15:0] right_speed,
  output      logic [7:0]         ctrl_flag
);
  import crc8fr_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int EXT_W = LEN_W + 3;
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK,
    PH_TRAILER
  } phase_t;

  logic             hunting;
  logic [7:0]       prev_byte;
  phase_t           phase;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] payload_count;
  logic [7:0]       running_crc;
  logic             trailer_seen;
  logic [7:0]       frame_bytes [SLOT_N];

  logic             accept;
  logic             emit_pending;
  logic             res_take;
  logic [7:0]       crc_next;
  logic [LEN_W-1:0] count_next;
  logic [EXT_W-1:0] count_ext;
  logic [EXT_W-1:0] len_ext;

  assign emit_pending = !hunting && (phase == PH_TRAILER) && trailer_seen;
  assign rx_stall     = res_valid && res_stall && emit_pending;
  assign accept       = rx_valid && !rx_stall;
  assign res_take     = res_valid && !res_stall;
  assign crc_next     = crc8_byte(running_crc, rx_byte);
  assign count_next   = payload_count + LEN_W'(1);
  assign count_ext    = EXT_W'(payload_count);
  assign len_ext      = EXT_W'(frame_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting       <= 1'b1;
      prev_byte     <= 8'h00;
      phase         <= PH_LEN;
      frame_len     <= '0;
      payload_count <= '0;
      running_crc   <= 8'h00;
      trailer_seen  <= 1'b0;
      res_valid     <= 1'b0;
      for (int i = 0; i < SLOT_N; i++) begin
        frame_bytes[i] <= 8'h00;
      end
    end else begin
      if (res_take) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        if (hunting) begin
          if (rx_byte == HDR1) begin
            if (prev_byte == HDR0) begin
              hunting       <= 1'b0;
              phase         <= PH_LEN;
              payload_count <= '0;
              trailer_seen  <= 1'b0;
              running_crc   <= HDR_CRC;
            end
          end else begin
            prev_byte <= rx_byte;
          end
        end else begin
          unique case (phase)
            PH_LEN: begin
              if (rx_byte > MAX_LEN) begin
                hunting      <= 1'b1;
                prev_byte    <= 8'h00;
                phase        <= PH_LEN;
                frame_len    <= '0;
                payload_count <= '0;
                running_crc  <= 8'h00;
                trailer_seen <= 1'b0;
              end else begin
                running_crc   <= crc_next;
                frame_len     <= rx_byte[LEN_W-1:0];
                payload_count <= '0;
                phase         <= (rx_byte == 8'h00) ? PH_CHECK : PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              if (count_ext < EXT_W'(SLOT_N)) begin
                frame_bytes[count_ext[2:0]] <= rx_byte;
              end
              running_crc <= crc_next;
              if (count_next >= frame_len) begin
                payload_count <= '0;
                phase         <= PH_CHECK;
              end else begin
                payload_count <= count_next;
              end
            end
            PH_CHECK: begin
              if (len_ext < EXT_W'(SLOT_N)) begin
                frame_bytes[len_ext[2:0]] <= rx_byte;
              end
              if (rx_byte != running_crc) begin
                hunting      <= 1'b1;
                prev_byte    <= 8'h00;
                phase        <= PH_LEN;
                frame_len    <= '0;
                payload_count <= '0;
                running_crc  <= 8'h00;
                trailer_seen <= 1'b0;
              end else begin
                phase        <= PH_TRAILER;
                trailer_seen <= 1'b0;
              end
            end
            PH_TRAILER: begin
              if (!trailer_seen) begin
                trailer_seen <= 1'b1;
              end else begin
                res_valid    <= 1'b1;
                hunting      <= 1'b1;
                prev_byte    <= 8'h00;
                phase        <= PH_LEN;
                frame_len    <= '0;
                payload_count <= '0;
                running_crc  <= 8'h00;
                trailer_seen <= 1'b0;
              end
            end
            default: begin
              phase <= PH_LEN;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_pending) begin
      left_speed  <= {frame_bytes[1], frame_bytes[0]};
      right_speed <= {frame_bytes[3], frame_bytes[2]};
      ctrl_flag   <= frame_bytes[4];
    end
  end

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid)
    else $error("input stalled with no result held");

  a_len_limit: assert property (@(posedge clk) disable iff (rst)
    !hunting && phase != PH_LEN |-> 8'(frame_len) <= MAX_LEN)
    else $error("frame length above limit");

  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    !hunting && phase == PH_PAYLOAD |-> payload_count < frame_len)
    else $error("payload count ran past frame length");

  a_emit_rehunt: assert property (@(posedge clk) disable iff (rst)
    accept && emit_pending |=> res_valid && hunting && prev_byte == 8'h00)
    else $error("frame end did not load result and resume hunting");

  a_hunt_idle: assert property (@(posedge clk) disable iff (rst)
    hunting |-> running_crc == 8'h00 || phase == PH_LEN)
    else $error("hunting with stale frame state");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for the CRC-8 framed packet receiver: framed byte beats in,
// speed/flag results out, checked against an in-bench frame parser.
// Depends on crc8fr_pkg and crc8_framed_packet_receiver.
`timescale 1ns / 100ps

module testbench;
  import crc8fr_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 200;

  typedef enum logic [1:0] {ST_LEN, ST_BODY, ST_CHECK, ST_TAIL} rx_phase_e;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [7:0]         flag;
  } speeds_t;

  typedef struct {
    logic [7:0] data;
    bit         wait_idle;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic [7:0]         ctrl_flag;

  crc8_framed_packet_receiver dut (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .left_speed (left_speed),
    .right_speed(right_speed),
    .ctrl_flag  (ctrl_flag)
  );

  pending_t   beat_q[$];
  speeds_t    speed_q[$];
  logic [7:0] body_q[$];
  bit         drain_next = 1'b0;
  int         frame_beats = 0;
  int         n_acc = 0;
  int         n_pred = 0;
  int         n_got = 0;
  int         errors = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;
  int         calm_left = 50;

  // parser state
  bit         hunt_on = 1'b1;
  logic [7:0] last_byte = 8'h00;
  rx_phase_e  ph = ST_LEN;
  logic [3:0] flen = 4'd0;
  logic [3:0] fcnt = 4'd0;
  logic [7:0] crc_acc = 8'h00;
  bit         tail_hit = 1'b0;
  logic [7:0] frame_slot [5] = '{default: 8'h00};

  initial forever #5 clk = ~clk;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ d[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ CRC_POLY;
    end
    return crc;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic resume_hunt();
    hunt_on  = 1'b1;
    last_byte = 8'h00;
    ph       = ST_LEN;
    flen     = 4'd0;
    fcnt     = 4'd0;
    crc_acc  = 8'h00;
    tail_hit = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit got, output speeds_t r);
    got = 1'b0;
    r   = '0;
    if (hunt_on) begin
      if (b == HDR1) begin
        if (last_byte == HDR0) begin
          hunt_on  = 1'b0;
          ph       = ST_LEN;
          fcnt     = 4'd0;
          tail_hit = 1'b0;
          crc_acc  = crc8_step(crc8_step(8'h00, HDR0), HDR1);
        end
      end else begin
        last_byte = b;
      end
    end else begin
      case (ph)
        ST_LEN: begin
          if (b > MAX_PAYLOAD) begin
            resume_hunt();
          end else begin
            crc_acc = crc8_step(crc_acc, b);
            flen    = b[3:0];
            fcnt    = 4'd0;
            ph      = (b == 8'h00) ? ST_CHECK : ST_BODY;
          end
        end
        ST_BODY: begin
          if (fcnt < 5) frame_slot[fcnt] = b;
          crc_acc = crc8_step(crc_acc, b);
          fcnt    = fcnt + 4'd1;
          if (fcnt >= flen) begin
            fcnt = 4'd0;
            ph   = ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (flen < 5) frame_slot[flen] = b;
          if (b != crc_acc) begin
            resume_hunt();
          end else begin
            ph       = ST_TAIL;
            tail_hit = 1'b0;
          end
        end
        default: begin
          if (!tail_hit) begin
            tail_hit = 1'b1;
          end else begin
            got     = 1'b1;
            r.left  = {frame_slot[1], frame_slot[0]};
            r.right = {frame_slot[3], frame_slot[2]};
            r.flag  = frame_slot[4];
            resume_hunt();
          end
        end
      endcase
    end
  endtask

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic push_beat(input logic [7:0] b);
    beat_q.push_back('{data: b, wait_idle: drain_next});
    drain_next = 1'b0;
  endtask

  task automatic push_frame(input bit corrupt);
    logic [7:0] crc;
    crc = crc8_step(crc8_step(8'h00, HDR0), HDR1);
    push_beat(HDR0);
    push_beat(HDR1);
    push_beat(8'(body_q.size()));
    crc = crc8_step(crc, 8'(body_q.size()));
    foreach (body_q[i]) begin
      push_beat(body_q[i]);
      crc = crc8_step(crc, body_q[i]);
    end
    if (corrupt) crc ^= 8'($urandom_range(1, 255));
    push_beat(crc);
    push_beat(8'($urandom));
    push_beat(8'($urandom));
    frame_beats += body_q.size() + 6;
    body_q.delete();
  endtask

  task automatic fill_body(input int len);
    repeat (len) body_q.push_back(pick_byte());
  endtask

  // alternate stretches with and without idling
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      <= !calm;
      calm_left <= calm ? $urandom_range(100, 300) : $urandom_range(20, 80);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // driver
  int unsigned tx_gap = 0;
  always @(posedge clk) begin
    bit      got;
    speeds_t r;
    int      pending;
    got = 1'b0;
    if (rst) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && !rx_stall) begin
        parse_byte(rx_byte, got, r);
        if (got) speed_q.push_back(r);
        n_acc  <= n_acc + 1;
        n_pred <= n_pred + int'(got);
      end
      pending = n_pred + int'(got) - n_got;
      if (!(rx_valid && rx_stall)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          rx_valid <= 1'b0;
        end else if (beat_q.size() > 0 && (!beat_q[0].wait_idle || pending == 0)) begin
          rx_byte  <= beat_q.pop_front().data;
          rx_valid <= 1'b1;
          tx_gap   = calm ? 0 : pick_gap();
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stall
  int          seen = 0;
  int unsigned hold_left = 0;
  int unsigned rcv_gap = 0;
  always @(posedge clk) begin
    speeds_t exp_r;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        n_got <= n_got + 1;
        seen++;
        if (speed_q.size() == 0) begin
          log_error($sformatf("unexpected result left=%0d right=%0d flag=%0h",
                              left_speed, right_speed, ctrl_flag));
        end else begin
          exp_r = speed_q.pop_front();
          if (left_speed !== exp_r.left)
            log_error($sformatf("left_speed exp %0d got %0d", exp_r.left, left_speed));
          if (right_speed !== exp_r.right)
            log_error($sformatf("right_speed exp %0d got %0d", exp_r.right, right_speed));
          if (ctrl_flag !== exp_r.flag)
            log_error($sformatf("ctrl_flag exp %0h got %0h", exp_r.flag, ctrl_flag));
        end
        if (seen == 5 || seen == 40) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
        rcv_gap = calm ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** crc8_framed_packet_receiver: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sel;
    int len;
    int total;
    int next_drain;

    // directed: stray 0xAA, zero length, extreme speeds, oversize length, bad check
    push_beat(HDR1);
    push_frame(1'b0);
    body_q = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF};
    push_frame(1'b0);
    push_beat(HDR0);
    push_beat(HDR1);
    push_beat(8'(MAX_PAYLOAD + 1));
    body_q = '{8'h12};
    push_frame(1'b1);

    next_drain = 300;
    while (frame_beats < 1300) begin
      sel = $urandom_range(99);
      if (frame_beats >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 300;
      end
      if (sel < 65) begin
        len = $urandom_range(99);
        if (len < 10) len = MAX_PAYLOAD;
        else if (len < 55) len = $urandom_range(0, 5);
        else len = $urandom_range(0, MAX_PAYLOAD);
        fill_body(len);
        push_frame(1'b0);
      end else if (sel < 75) begin
        fill_body($urandom_range(0, MAX_PAYLOAD));
        push_frame(1'b1);
      end else if (sel < 82) begin
        push_beat(HDR0);
        push_beat(HDR1);
        push_beat($urandom_range(3) == 0 ? 8'hFF : 8'($urandom_range(MAX_PAYLOAD + 1, 254)));
        frame_beats += 3;
      end else if (sel < 90) begin
        len = $urandom_range(1, MAX_PAYLOAD);
        push_beat(HDR0);
        push_beat(HDR1);
        push_beat(8'(len));
        len = $urandom_range(0, len - 1);
        repeat (len) push_beat(pick_byte());
        frame_beats += 3 + len;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(3))
            0: push_beat(HDR0);
            1: push_beat(HDR1);
            default: push_beat(8'($urandom));
          endcase
        end
      end
    end
    total = beat_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (n_acc != total || n_pred != n_got);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("** crc8_framed_packet_receiver: PASSED **");
    end else begin
      $display("** crc8_framed_packet_receiver: FAILED **");
    end
    $finish;
  end

endmodule

// ===== crc8_framed_packet_receiver.f =====
rtl/crc8fr_pkg.sv
rtl/crc8_framed_packet_receiver.sv
dv/testbench.sv
